@@ hdl/pmst_pkg.sv @@
// Package for the Prim spanning tree block: field widths, operation and
// condition codes, control structs and the sequencer's microprogram.
// No dependencies; the sequencer, datapath, top level and checker import it.
`default_nettype none

package pmst_pkg;

  localparam int unsigned VertexW  = 5;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned CountW   = 6;
  localparam int unsigned TdataW   = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned StepW    = 3;

  localparam logic [CountW-1:0] VertexCountReset = 6'd32;

  // Register indexes (word index taken from paddr[2]).
  localparam logic RegVertexCount = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } op_e;

  typedef logic [StepW-1:0] step_t;

  // Program steps.
  localparam step_t StepIdle   = 3'd0;
  localparam step_t StepInit   = 3'd1;
  localparam step_t StepRound  = 3'd2;
  localparam step_t StepScan   = 3'd3;
  localparam step_t StepDrain  = 3'd4;
  localparam step_t StepEmit   = 3'd5;
  localparam step_t StepNext   = 3'd6;
  localparam step_t StepReturn = 3'd7;

  typedef enum logic [2:0] {
    COND_TRUE      = 3'd0,
    COND_RUN       = 3'd1,
    COND_ONE       = 3'd2,
    COND_SCAN_LAST = 3'd3,
    COND_OUT_FREE  = 3'd4,
    COND_MORE      = 3'd5
  } cond_e;

  // Control lines from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic init_sel;
    logic clr_scan;
    logic scan_en;
    logic emit;
  } ctrl_t;

  // Status lines from the datapath back to the sequencer.
  typedef struct packed {
    logic run_req;
    logic one_vertex;
    logic scan_last;
    logic out_free;
    logic more_rounds;
  } cond_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    logic  jmp_on;
    step_t target;
  } uword_t;

  // Microprogram: the next step is target when the selected condition equals
  // jmp_on, otherwise the following step.
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    w = '{ctrl: '0, cond: COND_TRUE, jmp_on: 1'b0, target: StepIdle};
    case (pc)
      StepIdle: begin
        w.ctrl.in_ready = 1'b1;
        w.cond          = COND_RUN;
        w.jmp_on        = 1'b0;
        w.target        = StepIdle;
      end
      StepInit: begin
        w.ctrl.init_sel = 1'b1;
        w.cond          = COND_ONE;
        w.jmp_on        = 1'b1;
        w.target        = StepIdle;
      end
      StepRound: begin
        w.ctrl.clr_scan = 1'b1;
      end
      StepScan: begin
        w.ctrl.scan_en = 1'b1;
        w.cond         = COND_SCAN_LAST;
        w.jmp_on       = 1'b0;
        w.target       = StepScan;
      end
      StepDrain: begin
        w.cond = COND_TRUE;
      end
      StepEmit: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_OUT_FREE;
        w.jmp_on    = 1'b0;
        w.target    = StepEmit;
      end
      StepNext: begin
        w.cond   = COND_MORE;
        w.jmp_on = 1'b1;
        w.target = StepRound;
      end
      StepReturn: begin
        w.cond   = COND_TRUE;
        w.jmp_on = 1'b1;
        w.target = StepIdle;
      end
      default: begin
        w.cond   = COND_TRUE;
        w.jmp_on = 1'b1;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pmst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none

module pmst_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/pmst_useq.sv @@
// Microcoded sequencer: step counter, microprogram table and jump logic.
// Depends on pmst_pkg for the control word, condition codes and program.
`default_nettype none

module pmst_useq
  import pmst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cond_t cond_i,
  output      ctrl_t ctrl_o
);

  step_t  pc_q, pc_d;
  uword_t uw;
  logic   cond_val;

  assign uw     = ucode(pc_q);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    case (uw.cond)
      COND_TRUE:      cond_val = 1'b1;
      COND_RUN:       cond_val = cond_i.run_req;
      COND_ONE:       cond_val = cond_i.one_vertex;
      COND_SCAN_LAST: cond_val = cond_i.scan_last;
      COND_OUT_FREE:  cond_val = cond_i.out_free;
      COND_MORE:      cond_val = cond_i.more_rounds;
      default:        cond_val = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_val == uw.jmp_on) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pmst_datapath.sv @@
// Datapath of the spanning tree engine: scan counters, selected-vertex bits,
// best-edge compare, round counter and the output register.
// Depends on pmst_pkg; reads the weight matrix through pmst_ram.
`default_nettype none

module pmst_datapath
  import pmst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire ctrl_t                                       ctrl_i,
  output      cond_t                                       cond_o,
  input  wire logic                                        run_req_i,
  input  wire logic [CountW-1:0]                           v_used_i,
  output      logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] raddr_o,
  input  wire logic [WEIGHT_BITS-1:0]                      rdata_i,
  input  wire logic                                        out_ready_i,
  output      logic                                        out_valid_o,
  output      logic [VertexW-1:0]                          out_from_o,
  output      logic [VertexW-1:0]                          out_to_o,
  output      logic [WeightW-1:0]                          out_weight_o,
  output      logic                                        out_not_found_o,
  output      logic                                        out_last_o
);

  localparam int unsigned VB = $clog2(MAX_VERTICES);
  localparam int unsigned AW = $clog2(MAX_VERTICES*MAX_VERTICES);

  logic [VB-1:0]           i_q, j_q;
  logic [VB-1:0]           p_i_q, p_j_q;
  logic                    p_valid_q, p_ok_q;
  logic                    found_q;
  logic [WEIGHT_BITS-1:0]  best_q;
  logic [VB-1:0]           bx_q, by_q;
  logic [MAX_VERTICES-1:0] sel_q;
  logic [CountW-1:0]       rcnt_q;
  logic [CountW-1:0]       last_idx;
  logic                    j_wrap, hit, out_free, do_emit;
  logic                    out_valid_q;
  logic [VertexW-1:0]      o_from_q, o_to_q;
  logic [WeightW-1:0]      o_weight_q;
  logic                    o_nf_q, o_last_q;

  assign last_idx = v_used_i - CountW'(1);
  assign j_wrap   = (CountW'(j_q) == last_idx);
  assign raddr_o  = AW'(i_q) * AW'(MAX_VERTICES) + AW'(j_q);

  // The entry read in the previous cycle is valid now; candidates keep the
  // first of equal weights, which gives the lowest source then destination.
  assign hit = p_valid_q && p_ok_q && (rdata_i != '0) && (!found_q || rdata_i < best_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign do_emit  = ctrl_i.emit && out_free;

  assign cond_o.run_req     = run_req_i;
  assign cond_o.one_vertex  = (v_used_i == CountW'(1));
  assign cond_o.scan_last   = (CountW'(i_q) == last_idx) && j_wrap;
  assign cond_o.out_free    = out_free;
  assign cond_o.more_rounds = (rcnt_q != last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q       <= '0;
      j_q       <= '0;
      p_valid_q <= 1'b0;
      found_q   <= 1'b0;
      sel_q     <= '0;
      rcnt_q    <= '0;
    end else begin
      p_valid_q <= ctrl_i.scan_en;
      if (ctrl_i.clr_scan) begin
        i_q     <= '0;
        j_q     <= '0;
        found_q <= 1'b0;
      end else begin
        if (ctrl_i.scan_en) begin
          if (j_wrap) begin
            j_q <= '0;
            i_q <= i_q + VB'(1);
          end else begin
            j_q <= j_q + VB'(1);
          end
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (ctrl_i.init_sel) begin
        sel_q    <= MAX_VERTICES'(1);
        rcnt_q   <= '0;
      end else if (do_emit) begin
        sel_q[by_q] <= 1'b1;
        rcnt_q      <= rcnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_ok_q <= sel_q[i_q] && !sel_q[j_q];
    if (ctrl_i.clr_scan) begin
      best_q <= '0;
      bx_q   <= '0;
      by_q   <= '0;
    end else if (hit) begin
      best_q <= rdata_i;
      bx_q   <= p_i_q;
      by_q   <= p_j_q;
    end
  end

  // Vertex indexes travel alongside the RAM read.
  always_ff @(posedge clk_i) begin
    p_i_q <= i_q;
    p_j_q <= j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      o_from_q   <= VertexW'(bx_q);
      o_to_q     <= VertexW'(by_q);
      o_weight_q <= WeightW'(best_q);
      o_nf_q     <= !found_q;
      o_last_q   <= (rcnt_q == v_used_i - CountW'(2));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_from_o      = o_from_q;
  assign out_to_o        = o_to_q;
  assign out_weight_o    = o_weight_q;
  assign out_not_found_o = o_nf_q;
  assign out_last_o      = o_last_q;

endmodule

`default_nettype wire

@@ hdl/prim_minimum_spanning_tree.sv @@
// Top level of the Prim minimum spanning tree engine.
// Depends on pmst_pkg, pmst_ram, pmst_useq and pmst_datapath.
//
// Usage. Items arrive on the s_axis stream. With tuser at the write code a
// beat stores one weight of the adjacency matrix at (row, column); a weight
// of zero means no edge, and rows or columns beyond the matrix are dropped.
// With tuser at the run code the block grows a spanning tree from vertex 0
// over the first vertex_count vertices and sends vertex_count-1 edge beats
// on m_axis, the final one with tlast high. A round that finds no edge sends
// vertex 0 to vertex 0 with weight 0 and tuser (not found) high.
//
// Flow. Write beats are taken one per cycle while the block is idle. A run
// holds s_axis_tready low while it works: each round the microprogram
// clears the scan, reads all V*V matrix entries (V the vertex count in use)
// through the single read port of the weight RAM, one per cycle, then
// drains the read pipeline and emits the edge, waiting while the receiver stalls.
//
// Reset clears the sequencer, the selected-vertex bits and the output valid,
// and sets vertex_count to 32; the weight matrix is not cleared and must be
// written before a run reads it. When the receiver stalls, the finished edge
// waits in the output register and the sequencer holds before emitting the
// next one, so no result is lost. vertex_count is written over APB at byte
// address 0 and should only change while the block is idle.

`default_nettype none

module prim_minimum_spanning_tree
  import pmst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream. tdata: row[4:0], column[9:5], weight[25:10], zeros above.
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [TdataW-1:0]   s_axis_tdata,
  // tuser: operation (0 write weight, 1 run).
  input  wire logic                s_axis_tuser,
  // Result stream. tdata: from_vertex[4:0], to_vertex[9:5],
  // edge_weight[25:10], zeros above.
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [TdataW-1:0]   m_axis_tdata,
  // tuser: not_found.
  output      logic                m_axis_tuser,
  output      logic                m_axis_tlast,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready
);

  localparam int unsigned Depth  = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned VLimit = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int unsigned RowCmpW = VertexW + 2;

  ctrl_t ctrl;
  cond_t cond;

  logic [CountW-1:0]      vc_q;
  logic [CountW-1:0]      v_used;
  logic                   in_fire, run_req, wr_en, in_range;
  logic [VertexW-1:0]     in_row, in_col;
  logic [WeightW-1:0]     in_weight;
  logic [AW-1:0]          waddr, raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [VertexW-1:0]     out_from, out_to;
  logic [WeightW-1:0]     out_weight;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VertexCountReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegVertexCount) begin
      vc_q <= pwdata[CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegVertexCount) begin
      prdata[CountW-1:0] = vc_q;
    end
  end

  // Vertex count in use, held to 1 .. min(MAX_VERTICES, 32).
  always_comb begin
    if (vc_q == '0) begin
      v_used = CountW'(1);
    end else if (vc_q > CountW'(VLimit)) begin
      v_used = CountW'(VLimit);
    end else begin
      v_used = vc_q;
    end
  end

  // Input beat decode.
  assign s_axis_tready = ctrl.in_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_row        = s_axis_tdata[VertexW-1:0];
  assign in_col        = s_axis_tdata[2*VertexW-1:VertexW];
  assign in_weight     = s_axis_tdata[2*VertexW+WeightW-1:2*VertexW];
  assign run_req       = s_axis_tvalid && (s_axis_tuser == OP_RUN);
  assign in_range      = (RowCmpW'(in_row) < RowCmpW'(MAX_VERTICES)) &&
                         (RowCmpW'(in_col) < RowCmpW'(MAX_VERTICES));
  assign wr_en         = in_fire && (s_axis_tuser == OP_WRITE) && in_range;
  assign waddr         = AW'(in_row) * AW'(MAX_VERTICES) + AW'(in_col);

  pmst_ram #(
    .Width (WEIGHT_BITS),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (WEIGHT_BITS'(in_weight)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pmst_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  pmst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cond_o          (cond),
    .run_req_i       (run_req),
    .v_used_i        (v_used),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_from_o      (out_from),
    .out_to_o        (out_to),
    .out_weight_o    (out_weight),
    .out_not_found_o (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TdataW - 2*VertexW - WeightW){1'b0}}, out_weight, out_to, out_from};

endmodule

`default_nettype wire

@@ hdl/pmst_checker.sv @@
// Port-level checks for the Prim spanning tree block, bound to its top level.
// Depends on pmst_pkg and on prim_minimum_spanning_tree.
`default_nettype none

module pmst_checker
  import pmst_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [TdataW-1:0]   m_axis_tdata,
  input wire logic                m_axis_tuser,
  input wire logic                m_axis_tlast,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [ApbAddrW-1:0] paddr,
  input wire logic [ApbDataW-1:0] pwdata,
  input wire logic [ApbDataW-1:0] prdata,
  input wire logic                pready
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // While a run still owes edges, no new item is taken.
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a run");

  // A vertex count write reads back on the following cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == RegVertexCount |=>
      paddr[2] != RegVertexCount || prdata[CountW-1:0] == $past(pwdata[CountW-1:0]))
    else $error("vertex count read back wrong");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (.*);

`default_nettype wire
